>>> hdl/lepe_pkg.sv
// shared types, constants and the raised-cosine table for the led effect pulse encoder
// used by lepe_ctrl, lepe_dp and the top level; depends on nothing
`default_nettype none

package lepe_pkg;

  // sizes of the effect table and of one led word
  localparam int COS_TABLE_SIZE = 256;
  localparam int BITS_PER_LED   = 24;

  localparam int COS_IDX_W  = $clog2(COS_TABLE_SIZE);
  localparam int COS_VAL_W  = 9;
  localparam int DIV_CNT_W  = $clog2(COS_IDX_W);
  localparam int BIT_CNT_W  = $clog2(BITS_PER_LED);

  // field and register widths
  localparam int CH_W        = 8;
  localparam int LED_IDX_W   = 8;
  localparam int DUTY_W      = 16;
  localparam int IN_DATA_W   = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ELAPSED_W   = 18;
  localparam int HALF_W      = 17;
  localparam int PROD_W      = 17;
  localparam int RECIP_W     = 17;
  localparam int RECIP_PROD_W = 34;

  localparam int MS_PER_SEC  = 1000;
  localparam int MS_PER_HALF = 500;
  localparam logic [COS_VAL_W-1:0] FACTOR_FULL = 9'd256;

  // x / 3 == (x * DIV3_RECIP) >> DIV3_SHIFT for any x below 2^17
  localparam logic [RECIP_W-1:0] DIV3_RECIP = 17'd87382;
  localparam int DIV3_SHIFT = 18;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_STATIC,
    MODE_BLINK,
    MODE_BREATHE
  } mode_t;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BRIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PWM    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FACT,
    ST_MUL,
    ST_SCALE,
    ST_EMIT,
    ST_GAP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic tick_en;
    logic pix_load;
    logic div_step;
    logic fact_en;
    logic mul_en;
    logic scale_en;
    logic emit_bit;
    logic emit_last;
    logic emit_gap;
  } lepe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_chain;
    logic is_last;
    logic out_free;
  } lepe_stat_t;

  typedef logic [COS_VAL_W-1:0] cos_tab_t [COS_TABLE_SIZE];

  // raised cosine in q1.8, polynomial form of cos around zero with quadrant folding
  function automatic logic [COS_VAL_W-1:0] raised_cos(int i);
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] u3;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] c;
    logic [63:0] v;
    logic        flip;
    flip = 1'b0;
    p = (64'(i) << 16) / COS_TABLE_SIZE;
    if (p >= 64'd32768) p = 64'd65536 - p;
    if (p > 64'd16384) begin
      q = 64'd32768 - p;
      flip = 1'b1;
    end else begin
      q = p;
    end
    t = (q * 64'd411775) >> 16;
    u = (t * t) >> 16;
    u2 = (u * u) >> 16;
    u3 = (u2 * u) >> 16;
    pos = 64'd65536 + u2 / 64'd24;
    neg = u / 64'd2 + u3 / 64'd720;
    c = (neg > pos) ? 64'd0 : pos - neg;
    v = (64'd65536 + c + 64'd256) >> 9;
    if (v > 64'd256) v = 64'd256;
    if (flip) v = 64'd256 - v;
    return COS_VAL_W'(v);
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    for (int i = 0; i < COS_TABLE_SIZE; i++) begin
      tab[i] = raised_cos(i);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

`default_nettype wire

>>> hdl/led_effect_pulse_encoder.sv
// top level of the led effect pulse encoder: controller plus datapath
// depends on lepe_pkg, lepe_ctrl and lepe_dp
`default_nettype none

// Turns millisecond ticks and pixel colors into the compare values of a
// serial led chain's pulse timer. A tick word (in_tuser 0) advances the
// effect clock; it produces nothing. A pixel word (in_tuser 1) whose index
// is inside the chain is scaled by the effect (off, static brightness,
// blinking, or raised-cosine breathing) and sent as 24 duty words, green
// first and msb first: 2P/3 for a one, P/3 for a zero. The last pixel of
// the chain is followed by one reset-gap word (duty 0, out_tuser 1) that
// stands for the low latch gap. A pixel holds the input until its last
// duty word (or the reset-gap word) is registered: it passes through the
// bit-serial divider that maps elapsed time onto the cosine table, then
// factor lookup, multiply and scale, then one duty word per cycle while
// the output is not stalled. Pixels outside the chain are dropped. The
// output is registered, so the next word is accepted while the final duty
// of a pixel still waits for out_tready. Settings must be written through
// the cfg port only while the block is idle; the block does not enforce
// it. Changing the mode restarts the effect period.
module led_effect_pulse_encoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // settings: 0 mode, 1 brightness, 2 period seconds, 3 pwm period, 4 led count
  input  wire logic                              cfg_we,
  input  wire logic [lepe_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [lepe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input words
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lepe_pkg::IN_DATA_W-1:0]    in_tdata,  // led_index, red, green, blue
  input  wire logic                              in_tuser,  // cmd: 0 tick, 1 pixel
  // duty words
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lepe_pkg::DUTY_W-1:0]            out_tdata, // duty
  output logic                                   out_tuser, // reset_gap
  output logic                                   out_tlast
);

  lepe_pkg::lepe_cmd_t  cmd;
  lepe_pkg::lepe_stat_t stat;

  // sequencing: one pixel at a time
  lepe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // settings, effect timer, scaling and the output register
  lepe_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> hdl/lepe_ctrl.sv
// sequencer of the led effect pulse encoder: accept, divide, factor, scale, emit
// depends on lepe_pkg (state, command and status types)
`default_nettype none

module lepe_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_cmd,
  output logic                       in_tready,
  input  wire lepe_pkg::lepe_stat_t  stat,
  output lepe_pkg::lepe_cmd_t        cmd
);

  lepe_pkg::state_t state_r;
  lepe_pkg::state_t state_nxt;

  logic [lepe_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [lepe_pkg::BIT_CNT_W-1:0] bit_cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lepe_pkg::ST_IDLE: begin
        if (in_tvalid && in_cmd && stat.in_chain) state_nxt = lepe_pkg::ST_DIV;
      end
      lepe_pkg::ST_DIV: begin
        if (div_cnt_r == '0) state_nxt = lepe_pkg::ST_FACT;
      end
      lepe_pkg::ST_FACT:  state_nxt = lepe_pkg::ST_MUL;
      lepe_pkg::ST_MUL:   state_nxt = lepe_pkg::ST_SCALE;
      lepe_pkg::ST_SCALE: state_nxt = lepe_pkg::ST_EMIT;
      lepe_pkg::ST_EMIT: begin
        if (stat.out_free && bit_cnt_r == '0) begin
          state_nxt = stat.is_last ? lepe_pkg::ST_GAP : lepe_pkg::ST_IDLE;
        end
      end
      lepe_pkg::ST_GAP: begin
        if (stat.out_free) state_nxt = lepe_pkg::ST_IDLE;
      end
      default: state_nxt = lepe_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      lepe_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.tick_en = in_tvalid && !in_cmd;
        cmd.pix_load = in_tvalid && in_cmd && stat.in_chain;
      end
      lepe_pkg::ST_DIV:   cmd.div_step = 1'b1;
      lepe_pkg::ST_FACT:  cmd.fact_en = 1'b1;
      lepe_pkg::ST_MUL:   cmd.mul_en = 1'b1;
      lepe_pkg::ST_SCALE: cmd.scale_en = 1'b1;
      lepe_pkg::ST_EMIT: begin
        cmd.emit_bit = stat.out_free;
        cmd.emit_last = (bit_cnt_r == '0) && !stat.is_last;
      end
      lepe_pkg::ST_GAP:   cmd.emit_gap = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lepe_pkg::ST_IDLE;
      div_cnt_r <= '0;
      bit_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cmd.pix_load) begin
        div_cnt_r <= lepe_pkg::DIV_CNT_W'(lepe_pkg::COS_IDX_W - 1);
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      if (cmd.scale_en) begin
        bit_cnt_r <= lepe_pkg::BIT_CNT_W'(lepe_pkg::BITS_PER_LED - 1);
      end else if (cmd.emit_bit) begin
        bit_cnt_r <= bit_cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/lepe_dp.sv
// datapath of the led effect pulse encoder: settings, elapsed timer, divider,
// effect factor, channel scaling, bit shifter and output register; depends on lepe_pkg
`default_nettype none

module lepe_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [lepe_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [lepe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic [lepe_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                                out_tready,
  input  wire lepe_pkg::lepe_cmd_t                 cmd,
  output lepe_pkg::lepe_stat_t                     stat,
  output logic                                     out_tvalid,
  output logic [lepe_pkg::DUTY_W-1:0]              out_tdata,
  output logic                                     out_tuser,
  output logic                                     out_tlast
);

  localparam int CH_W = lepe_pkg::CH_W;
  localparam int EW   = lepe_pkg::ELAPSED_W;
  localparam int IW   = lepe_pkg::COS_IDX_W;
  localparam int WW   = lepe_pkg::BITS_PER_LED;

  // settings
  lepe_pkg::mode_t                    mode_r;
  logic [CH_W-1:0]                    bright_r;
  logic [lepe_pkg::LED_IDX_W-1:0]     led_count_r;
  logic [EW-1:0]                      span_r;
  logic [lepe_pkg::HALF_W-1:0]        half_r;
  logic [lepe_pkg::DUTY_W-1:0]        one_r;
  logic [lepe_pkg::DUTY_W-1:0]        zero_r;

  logic [EW-1:0]                      elapsed_r;

  // pixel work registers
  logic [CH_W-1:0]                    red_r;
  logic [CH_W-1:0]                    green_r;
  logic [CH_W-1:0]                    blue_r;
  logic                               is_last_r;
  logic [EW-1:0]                      rem_r;
  logic [IW-1:0]                      quo_r;
  logic [lepe_pkg::COS_VAL_W-1:0]     factor_r;
  logic [lepe_pkg::PROD_W-1:0]        prod_red_r;
  logic [lepe_pkg::PROD_W-1:0]        prod_green_r;
  logic [lepe_pkg::PROD_W-1:0]        prod_blue_r;
  logic [WW-1:0]                      word_r;

  logic                               out_valid_r;
  logic [lepe_pkg::DUTY_W-1:0]        out_duty_r;
  logic                               out_gap_r;
  logic                               out_last_r;

  logic [lepe_pkg::LED_IDX_W-1:0]     in_led_index;
  logic [EW-1:0]                      span_calc;
  logic [lepe_pkg::HALF_W-1:0]        half_calc;
  logic [lepe_pkg::RECIP_PROD_W-1:0]  one_prod;
  logic [lepe_pkg::RECIP_PROD_W-1:0]  zero_prod;
  logic [EW:0]                        elapsed_inc;
  logic [EW:0]                        rem_dbl;
  logic [EW:0]                        span_ext;

  assign in_led_index = in_tdata[7:0];

  assign span_calc = EW'(cfg_wdata[CH_W-1:0]) * EW'(lepe_pkg::MS_PER_SEC);
  assign half_calc = lepe_pkg::HALF_W'(cfg_wdata[CH_W-1:0])
                   * lepe_pkg::HALF_W'(lepe_pkg::MS_PER_HALF);
  assign one_prod  = lepe_pkg::RECIP_PROD_W'({cfg_wdata, 1'b0})
                   * lepe_pkg::RECIP_PROD_W'(lepe_pkg::DIV3_RECIP);
  assign zero_prod = lepe_pkg::RECIP_PROD_W'(cfg_wdata)
                   * lepe_pkg::RECIP_PROD_W'(lepe_pkg::DIV3_RECIP);

  assign elapsed_inc = {1'b0, elapsed_r} + 1'b1;
  assign span_ext    = {1'b0, span_r};
  assign rem_dbl     = {rem_r, 1'b0};

  assign stat.in_chain = in_led_index < led_count_r;
  assign stat.is_last  = is_last_r;
  assign stat.out_free = !out_valid_r || out_tready;

  // off mode gives zero, static mode divides by 255, blink and breathe shift by 8
  function automatic logic [CH_W-1:0] scale_ch(logic [lepe_pkg::PROD_W-1:0] p,
                                               lepe_pkg::mode_t m);
    logic [lepe_pkg::PROD_W:0] s;
    s = {1'b0, p} + {9'd0, p[lepe_pkg::PROD_W-1:8]} + 1'b1;
    unique case (m)
      lepe_pkg::MODE_OFF:    return '0;
      lepe_pkg::MODE_STATIC: return s[CH_W+7:8];
      default:               return p[CH_W+7:8];
    endcase
  endfunction

  // settings and the precomputed period bounds and duties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lepe_pkg::MODE_OFF;
      bright_r <= '0;
      led_count_r <= lepe_pkg::LED_IDX_W'(1);
      span_r <= '0;
      half_r <= '0;
      one_r <= '0;
      zero_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lepe_pkg::REG_MODE:   mode_r <= lepe_pkg::mode_t'(cfg_wdata[1:0]);
        lepe_pkg::REG_BRIGHT: bright_r <= cfg_wdata[CH_W-1:0];
        lepe_pkg::REG_PERIOD: begin
          span_r <= span_calc;
          half_r <= half_calc;
        end
        lepe_pkg::REG_PWM: begin
          one_r  <= one_prod[lepe_pkg::DIV3_SHIFT +: lepe_pkg::DUTY_W];
          zero_r <= zero_prod[lepe_pkg::DIV3_SHIFT +: lepe_pkg::DUTY_W];
        end
        lepe_pkg::REG_COUNT:  led_count_r <= cfg_wdata[lepe_pkg::LED_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // millisecond position within the effect period
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (cfg_we && cfg_addr == lepe_pkg::REG_MODE &&
                 cfg_wdata[1:0] != mode_r) begin
      elapsed_r <= '0;
    end else if (cmd.tick_en) begin
      elapsed_r <= (elapsed_inc >= span_ext) ? '0 : elapsed_inc[EW-1:0];
    end
  end

  // pixel pipeline
  always_ff @(posedge clk) begin
    if (cmd.pix_load) begin
      red_r <= in_tdata[15:8];
      green_r <= in_tdata[23:16];
      blue_r <= in_tdata[31:24];
      is_last_r <= in_led_index == (led_count_r - 1'b1);
      rem_r <= elapsed_r;
      quo_r <= '0;
    end
    // restoring divide: elapsed * table size / span, one quotient bit per step
    if (cmd.div_step) begin
      if (rem_dbl >= span_ext) begin
        rem_r <= EW'(rem_dbl - span_ext);
        quo_r <= {quo_r[IW-2:0], 1'b1};
      end else begin
        rem_r <= rem_dbl[EW-1:0];
        quo_r <= {quo_r[IW-2:0], 1'b0};
      end
    end
    if (cmd.fact_en) begin
      unique case (mode_r)
        lepe_pkg::MODE_OFF:    factor_r <= '0;
        lepe_pkg::MODE_STATIC: factor_r <= {1'b0, bright_r};
        lepe_pkg::MODE_BLINK: begin
          factor_r <= (span_r != '0 && elapsed_r <= EW'(half_r))
                    ? lepe_pkg::FACTOR_FULL : '0;
        end
        lepe_pkg::MODE_BREATHE: begin
          priority if (span_r == '0) begin
            factor_r <= lepe_pkg::FACTOR_FULL;
          end else if (elapsed_r >= span_r) begin
            factor_r <= lepe_pkg::COS_TAB[IW'(lepe_pkg::COS_TABLE_SIZE - 1)];
          end else begin
            factor_r <= lepe_pkg::COS_TAB[quo_r];
          end
        end
        default: factor_r <= '0;
      endcase
    end
    if (cmd.mul_en) begin
      prod_red_r   <= lepe_pkg::PROD_W'(red_r) * lepe_pkg::PROD_W'(factor_r);
      prod_green_r <= lepe_pkg::PROD_W'(green_r) * lepe_pkg::PROD_W'(factor_r);
      prod_blue_r  <= lepe_pkg::PROD_W'(blue_r) * lepe_pkg::PROD_W'(factor_r);
    end
    if (cmd.scale_en) begin
      word_r <= WW'({scale_ch(prod_green_r, mode_r), scale_ch(prod_red_r, mode_r),
                     scale_ch(prod_blue_r, mode_r)});
    end else if (cmd.emit_bit) begin
      word_r <= word_r << 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_bit || cmd.emit_gap) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_bit) begin
      out_duty_r <= word_r[WW-1] ? one_r : zero_r;
      out_gap_r <= 1'b0;
      out_last_r <= cmd.emit_last;
    end else if (cmd.emit_gap) begin
      out_duty_r <= '0;
      out_gap_r <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_duty_r;
  assign out_tuser  = out_gap_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> hdl/lepe_checker.sv
// port-level checks for the led effect pulse encoder, bound to the top level
// depends on lepe_pkg and led_effect_pulse_encoder
`default_nettype none

module lepe_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              in_tuser,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [lepe_pkg::DUTY_W-1:0]       out_tdata,
  input wire logic                              out_tuser,
  input wire logic                              out_tlast
);

  // a stalled duty word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  // the reset-gap word is low and closes the run
  a_gap_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0 && out_tlast)
    else $error("reset gap word malformed");

  // a tick never blocks the input
  a_tick_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> in_tready)
    else $error("input blocked after a tick");

  // when ready for a new word, only the final word of a run may be pending
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("input ready while a run is unfinished");

endmodule

bind led_effect_pulse_encoder lepe_checker u_lepe_checker (.*);

`default_nettype wire
